// ===== sv/nls_pkg.sv =====
// Shared types and constants for the numeric literal scanner.
// Depends on nothing; every other file of the block imports it.
package nls_pkg;

   // Longest literal the length counters distinguish; longer ones saturate.
   localparam int unsigned MAX_LEN = 255;
   // Counters hold up to MAX_LEN + 1, which means "more than MAX_LEN".
   localparam int unsigned LEN_W = $clog2(MAX_LEN + 2);
   localparam logic [LEN_W-1:0] MAX_LEN_L = LEN_W'(MAX_LEN);
   localparam logic [LEN_W-1:0] LEN_OVER = LEN_W'(MAX_LEN + 1);
   // Width and ceiling of the reported length field.
   localparam int unsigned OUT_W = 8;
   localparam int unsigned OUT_MAX = 255;
   localparam int unsigned CP_W = 16;

   localparam logic [CP_W-1:0] CH_DOT = 16'h002E;
   localparam logic [CP_W-1:0] CH_0 = 16'h0030;
   localparam logic [CP_W-1:0] CH_1 = 16'h0031;
   localparam logic [CP_W-1:0] CH_7 = 16'h0037;
   localparam logic [CP_W-1:0] CH_9 = 16'h0039;
   localparam logic [CP_W-1:0] CH_UA = 16'h0041;
   localparam logic [CP_W-1:0] CH_UB = 16'h0042;
   localparam logic [CP_W-1:0] CH_UE = 16'h0045;
   localparam logic [CP_W-1:0] CH_UF = 16'h0046;
   localparam logic [CP_W-1:0] CH_UO = 16'h004F;
   localparam logic [CP_W-1:0] CH_UX = 16'h0058;
   localparam logic [CP_W-1:0] CH_LA = 16'h0061;
   localparam logic [CP_W-1:0] CH_LB = 16'h0062;
   localparam logic [CP_W-1:0] CH_LE = 16'h0065;
   localparam logic [CP_W-1:0] CH_LF = 16'h0066;
   localparam logic [CP_W-1:0] CH_LN = 16'h006E;
   localparam logic [CP_W-1:0] CH_LO = 16'h006F;
   localparam logic [CP_W-1:0] CH_LX = 16'h0078;
   localparam logic [CP_W-1:0] CH_USCORE = 16'h005F;
   localparam logic [CP_W-1:0] CH_PLUS = 16'h002B;
   localparam logic [CP_W-1:0] CH_MINUS = 16'h002D;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_ZERO   = 4'd1,
      PH_DOT    = 4'd2,
      PH_INT    = 4'd3,
      PH_FRAC   = 4'd4,
      PH_EXP_E  = 4'd5,
      PH_EXP_U  = 4'd6,
      PH_EXP_D  = 4'd7,
      PH_PREFIX = 4'd8,
      PH_DONE   = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2,
      RADIX_OCT = 2'd3
   } radix_type;

   typedef struct packed {
      phase_type        phase;
      logic [LEN_W-1:0] committed;
      logic [LEN_W-1:0] tentative;
      radix_type        radix;
      logic             overflow;
   } scan_state_type;

   // Character classes of one code point.
   typedef struct packed {
      logic dec;
      logic hex_letter;
      logic bin;
      logic oct;
      logic dot;
      logic zero;
      logic hex_mark;
      logic bin_mark;
      logic oct_mark;
      logic exp_mark;
      logic sign;
      logic uscore;
      logic big_n;
   } char_class_type;

endpackage

// ===== sv/numeric_literal_scanner.sv =====
// Top level of the numeric literal scanner: handshakes, registers, scan state.
// Depends on nls_pkg, nls_char_class and nls_step.
//
// The scanner takes one 16-bit code point per word and recognizes a numeric
// literal in the style of TypeScript: plain decimals, one fraction, 0x / 0b /
// 0o prefixed integers, underscores among digits, an exponent that counts only
// once it holds a digit, and an optional trailing n. A word with scan_start
// set opens a new scan and abandons any scan in progress without a result; a
// word with text_end set closes the text. When a character rejects the
// literal, or the text ends, exactly one result word gives the literal's
// length (0 if there is none), with length_saturated set when the literal was
// longer than the counter holds. Words after a decided scan and before the
// next scan_start produce nothing. The block takes one word every cycle: a
// word is captured in an input register, and from there the character
// classifier and the one-step transition logic update the scan state and load
// the result register. Only a stalled result that is still waiting, with
// another word behind it in the input register, holds off new words.

module numeric_literal_scanner (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [nls_pkg::CP_W-1:0]   req_code_point,
   input  logic                       req_scan_start,
   input  logic                       req_text_end,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [nls_pkg::OUT_W-1:0]  rsp_match_length,
   output logic                       rsp_length_saturated
);
   import nls_pkg::*;

   // Input register.
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [CP_W-1:0]   in_cp_ff;
   logic              in_start_ff;
   logic              in_end_ff;

   // Scan state carried from one character to the next.
   scan_state_type    state_ff;
   scan_state_type    state_in;

   // Result register.
   logic              out_valid_ff;
   logic              out_valid_in;
   logic [OUT_W-1:0]  out_len_ff;
   logic              out_sat_ff;

   char_class_type    cls;
   logic              step_emit;
   logic [OUT_W-1:0]  step_len;
   logic              step_sat;
   logic              advance;
   logic              take;
   logic              process;

   nls_char_class u_class (
      .code_point (in_cp_ff),
      .cls        (cls)
   );

   nls_step u_step (
      .cur              (state_ff),
      .cls              (cls),
      .scan_start       (in_start_ff),
      .text_end         (in_end_ff),
      .nxt              (state_in),
      .emit             (step_emit),
      .match_length     (step_len),
      .length_saturated (step_sat)
   );

   // The pipeline moves whenever the result register is free or being taken.
   assign advance = !out_valid_ff || !rsp_stall;
   assign process = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign take = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = process && step_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff <= '{phase: PH_IDLE, committed: '0, tentative: '0,
                       radix: RADIX_DEC, overflow: 1'b0};
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_cp_ff <= req_code_point;
         in_start_ff <= req_scan_start;
         in_end_ff <= req_text_end;
      end
      if (process && step_emit) begin
         out_len_ff <= step_len;
         out_sat_ff <= step_sat;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_match_length = out_len_ff;
   assign rsp_length_saturated = out_sat_ff;

endmodule

// ===== sv/nls_char_class.sv =====
// Character classifier for the numeric literal scanner.
// Depends on nls_pkg for the character codes and the class struct.
module nls_char_class (
   input  logic [nls_pkg::CP_W-1:0] code_point,
   output nls_pkg::char_class_type  cls
);
   import nls_pkg::*;

   always_comb begin
      cls.dec = (code_point >= CH_0) && (code_point <= CH_9);
      cls.hex_letter = ((code_point >= CH_LA) && (code_point <= CH_LF)) ||
                       ((code_point >= CH_UA) && (code_point <= CH_UF));
      cls.bin = (code_point == CH_0) || (code_point == CH_1);
      cls.oct = (code_point >= CH_0) && (code_point <= CH_7);
      cls.dot = (code_point == CH_DOT);
      cls.zero = (code_point == CH_0);
      cls.hex_mark = (code_point == CH_LX) || (code_point == CH_UX);
      cls.bin_mark = (code_point == CH_LB) || (code_point == CH_UB);
      cls.oct_mark = (code_point == CH_LO) || (code_point == CH_UO);
      cls.exp_mark = (code_point == CH_LE) || (code_point == CH_UE);
      cls.sign = (code_point == CH_PLUS) || (code_point == CH_MINUS);
      cls.uscore = (code_point == CH_USCORE);
      // Only a lower-case n ends a literal as a big integer.
      cls.big_n = (code_point == CH_LN);
   end

endmodule

// ===== sv/nls_step.sv =====
// Per-character transition of the numeric literal scanner.
// Depends on nls_pkg; fed by nls_char_class, registered by the top level.
module nls_step (
   input  nls_pkg::scan_state_type  cur,
   input  nls_pkg::char_class_type  cls,
   input  logic                     scan_start,
   input  logic                     text_end,
   output nls_pkg::scan_state_type  nxt,
   output logic                     emit,
   output logic [nls_pkg::OUT_W-1:0] match_length,
   output logic                     length_saturated
);
   import nls_pkg::*;

   typedef enum logic [1:0] {
      ACT_MORE   = 2'd0,
      ACT_REJECT = 2'd1,
      ACT_FINAL  = 2'd2
   } act_type;

   function automatic logic [LEN_W-1:0] bump(input logic [LEN_W-1:0] v);
      return (v > MAX_LEN_L) ? LEN_OVER : v + LEN_W'(1);
   endfunction

   logic [LEN_W-1:0] base_committed;
   logic [LEN_W-1:0] bump_c;
   logic [LEN_W-1:0] bump_t;
   logic [LEN_W-1:0] len_cl;
   logic             sat_cl;
   logic             active;
   logic             run_mant;
   logic             allow_dot;
   logic             radix_ok;
   act_type          act;

   assign base_committed = scan_start ? '0 : cur.committed;
   assign bump_c = bump(base_committed);
   assign bump_t = bump(cur.tentative);

   always_comb begin
      case (cur.radix)
         RADIX_HEX: radix_ok = cls.dec || cls.hex_letter;
         RADIX_BIN: radix_ok = cls.bin;
         default:   radix_ok = cls.oct;
      endcase
   end

   always_comb begin
      nxt = cur;
      act = ACT_MORE;
      active = 1'b1;
      run_mant = 1'b0;
      allow_dot = 1'b0;
      if (scan_start) begin
         nxt.committed = '0;
         nxt.tentative = '0;
         nxt.radix = RADIX_DEC;
         nxt.overflow = 1'b0;
         if (cls.dot) begin
            nxt.tentative = LEN_W'(1);
            nxt.phase = PH_DOT;
         end else if (cls.zero) begin
            nxt.committed = LEN_W'(1);
            nxt.phase = PH_ZERO;
         end else begin
            nxt.phase = PH_INT;
            run_mant = 1'b1;
            allow_dot = 1'b1;
         end
      end else if (cur.phase == PH_IDLE || cur.phase == PH_DONE) begin
         active = 1'b0;
      end else begin
         unique case (cur.phase)
            PH_ZERO: begin
               if (cls.hex_mark || cls.bin_mark || cls.oct_mark) begin
                  nxt.radix = cls.hex_mark ? RADIX_HEX :
                              cls.bin_mark ? RADIX_BIN : RADIX_OCT;
                  nxt.committed = bump_c;
                  nxt.phase = PH_PREFIX;
               end else begin
                  nxt.phase = PH_INT;
                  run_mant = 1'b1;
                  allow_dot = 1'b1;
               end
            end
            PH_DOT: begin
               if (cls.dec) begin
                  nxt.committed = bump_t;
                  nxt.phase = PH_FRAC;
               end else begin
                  act = ACT_REJECT;
               end
            end
            PH_INT: begin
               run_mant = 1'b1;
               allow_dot = 1'b1;
            end
            PH_FRAC: begin
               run_mant = 1'b1;
            end
            PH_EXP_E: begin
               if (cls.sign || cls.uscore) begin
                  nxt.tentative = bump_t;
                  nxt.phase = PH_EXP_U;
               end else if (cls.dec) begin
                  nxt.committed = bump_t;
                  nxt.phase = PH_EXP_D;
               end else begin
                  act = ACT_REJECT;
               end
            end
            PH_EXP_U: begin
               if (cls.uscore) begin
                  nxt.tentative = bump_t;
               end else if (cls.dec) begin
                  nxt.committed = bump_t;
                  nxt.phase = PH_EXP_D;
               end else begin
                  act = ACT_REJECT;
               end
            end
            PH_EXP_D: begin
               if (cls.dec || cls.uscore) begin
                  nxt.committed = bump_c;
               end else if (cls.big_n) begin
                  nxt.committed = bump_c;
                  act = ACT_FINAL;
               end else begin
                  act = ACT_REJECT;
               end
            end
            PH_PREFIX: begin
               if (cls.uscore || radix_ok) begin
                  nxt.committed = bump_c;
               end else if (cls.big_n) begin
                  nxt.committed = bump_c;
                  act = ACT_FINAL;
               end else begin
                  act = ACT_REJECT;
               end
            end
            default: begin
               act = ACT_REJECT;
            end
         endcase
      end

      // Integer and fraction digits share one body; a dot is only legal
      // in the integer part.
      if (run_mant) begin
         if (cls.dec || cls.uscore) begin
            nxt.committed = bump_c;
         end else if (allow_dot && cls.dot) begin
            nxt.committed = bump_c;
            nxt.phase = PH_FRAC;
         end else if (cls.exp_mark) begin
            nxt.tentative = bump_c;
            nxt.phase = PH_EXP_E;
         end else if (cls.big_n) begin
            nxt.committed = bump_c;
            act = ACT_FINAL;
         end else begin
            act = ACT_REJECT;
         end
      end

      if (nxt.committed > MAX_LEN_L) begin
         nxt.overflow = 1'b1;
      end

      emit = active && ((act != ACT_MORE) || text_end);
      if (emit) begin
         nxt.phase = PH_DONE;
      end
   end

   always_comb begin
      len_cl = nxt.committed;
      sat_cl = nxt.overflow;
      if (len_cl > MAX_LEN_L) begin
         len_cl = MAX_LEN_L;
         sat_cl = 1'b1;
      end
      if (32'(len_cl) > OUT_MAX) begin
         match_length = OUT_W'(OUT_MAX);
         length_saturated = 1'b1;
      end else begin
         match_length = OUT_W'(len_cl);
         length_saturated = sat_cl;
      end
   end

endmodule

// ===== tb/tb_numeric_literal_scanner.sv =====
// Self-checking testbench for the numeric literal scanner: directed and random
// code-point streams with random idling on both channels. Depends on nls_pkg and
// numeric_literal_scanner; it contains the length predictor class as well.
import nls_pkg::*;

// What one character does to the literal being scanned.
typedef enum logic [1:0] {
   STEP_MORE,
   STEP_REJECT,
   STEP_FINAL
} scan_step_type;

// How the stimulus closes a scan.
typedef enum logic [1:0] {
   SCAN_CLOSE_TEXT_END,
   SCAN_CLOSE_REJECT,
   SCAN_LEFT_OPEN
} scan_close_type;

// Receiver stall patterns.
typedef enum logic [1:0] {
   STALL_NONE,
   STALL_LIGHT,
   STALL_HEAVY,
   STALL_TOGGLE
} stall_pattern_type;

typedef struct {
   logic [OUT_W-1:0] length;
   logic             saturated;
} length_result_type;

// Predicts the literal length reported for each scan and checks the result words.
class literal_length_board;
   phase_type         phase;
   logic [LEN_W-1:0]  committed;
   logic [LEN_W-1:0]  tentative;
   radix_type         radix;
   logic              overflow;
   length_result_type expected_q[$];
   int unsigned       failures;

   function new();
      phase = PH_IDLE;
      committed = '0;
      tentative = '0;
      radix = RADIX_DEC;
      overflow = 1'b0;
      failures = 0;
   endfunction

   function int unsigned outstanding();
      return expected_q.size();
   endfunction

   // Counters stop one past MAX_LEN, which stands for "too long".
   function logic [LEN_W-1:0] bump(logic [LEN_W-1:0] v);
      return (v > MAX_LEN_L) ? LEN_OVER : v + 1'b1;
   endfunction

   function void commit(logic [LEN_W-1:0] v);
      committed = v;
      if (v > MAX_LEN_L) overflow = 1'b1;
   endfunction

   function bit is_dec(logic [CP_W-1:0] c);
      return c >= CH_0 && c <= CH_9;
   endfunction

   function bit is_radix_digit(logic [CP_W-1:0] c);
      bit ok;
      case (radix)
         RADIX_HEX: ok = is_dec(c) || (c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF);
         RADIX_BIN: ok = c == CH_0 || c == CH_1;
         default:   ok = c >= CH_0 && c <= CH_7;
      endcase
      return ok;
   endfunction

   // Integer or fraction digits; a dot is only taken in the integer part.
   function scan_step_type take_mantissa(logic [CP_W-1:0] c, bit dot_allowed);
      scan_step_type act;
      act = STEP_REJECT;
      if (is_dec(c) || c == CH_USCORE) begin
         commit(bump(committed));
         act = STEP_MORE;
      end else if (dot_allowed && c == CH_DOT) begin
         commit(bump(committed));
         phase = PH_FRAC;
         act = STEP_MORE;
      end else if (c == CH_LE || c == CH_UE) begin
         tentative = bump(committed);
         phase = PH_EXP_E;
         act = STEP_MORE;
      end else if (c == CH_LN) begin
         commit(bump(committed));
         act = STEP_FINAL;
      end
      return act;
   endfunction

   function scan_step_type advance_scan(logic [CP_W-1:0] c);
      scan_step_type act;
      act = STEP_REJECT;
      case (phase)
         PH_ZERO: begin
            if (c == CH_LX || c == CH_UX || c == CH_LB || c == CH_UB ||
                c == CH_LO || c == CH_UO) begin
               if (c == CH_LX || c == CH_UX) radix = RADIX_HEX;
               else if (c == CH_LB || c == CH_UB) radix = RADIX_BIN;
               else radix = RADIX_OCT;
               commit(bump(committed));
               phase = PH_PREFIX;
               act = STEP_MORE;
            end else begin
               phase = PH_INT;
               act = take_mantissa(c, 1'b1);
            end
         end
         PH_DOT: begin
            if (is_dec(c)) begin
               commit(bump(tentative));
               phase = PH_FRAC;
               act = STEP_MORE;
            end
         end
         PH_INT: act = take_mantissa(c, 1'b1);
         PH_FRAC: act = take_mantissa(c, 1'b0);
         PH_EXP_E, PH_EXP_U: begin
            if (c == CH_USCORE || (phase == PH_EXP_E && (c == CH_PLUS || c == CH_MINUS))) begin
               tentative = bump(tentative);
               phase = PH_EXP_U;
               act = STEP_MORE;
            end else if (is_dec(c)) begin
               commit(bump(tentative));
               phase = PH_EXP_D;
               act = STEP_MORE;
            end
         end
         PH_EXP_D: begin
            if (is_dec(c) || c == CH_USCORE) begin
               commit(bump(committed));
               act = STEP_MORE;
            end else if (c == CH_LN) begin
               commit(bump(committed));
               act = STEP_FINAL;
            end
         end
         PH_PREFIX: begin
            if (c == CH_USCORE || is_radix_digit(c)) begin
               commit(bump(committed));
               act = STEP_MORE;
            end else if (c == CH_LN) begin
               commit(bump(committed));
               act = STEP_FINAL;
            end
         end
         default: act = STEP_REJECT;
      endcase
      return act;
   endfunction

   // Called for every accepted input word; queues a result when the scan is decided.
   function void note_word(logic [CP_W-1:0] c, logic start, logic last);
      scan_step_type     act;
      length_result_type r;
      int unsigned       len;
      if (start) begin
         committed = '0;
         tentative = '0;
         radix = RADIX_DEC;
         overflow = 1'b0;
         if (c == CH_DOT) begin
            tentative = 1;
            phase = PH_DOT;
            act = STEP_MORE;
         end else if (c == CH_0) begin
            commit(1);
            phase = PH_ZERO;
            act = STEP_MORE;
         end else begin
            phase = PH_INT;
            act = take_mantissa(c, 1'b1);
         end
      end else if (phase == PH_IDLE || phase == PH_DONE) begin
         return;
      end else begin
         act = advance_scan(c);
      end
      if (act == STEP_MORE && !last) return;
      phase = PH_DONE;
      len = committed;
      r.saturated = overflow;
      if (len > MAX_LEN) begin
         len = MAX_LEN;
         r.saturated = 1'b1;
      end
      if (len > OUT_MAX) begin
         len = OUT_MAX;
         r.saturated = 1'b1;
      end
      r.length = OUT_W'(len);
      expected_q.push_back(r);
   endfunction

   function void check_length(logic [OUT_W-1:0] got_length, logic got_saturated);
      length_result_type want;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected result word, length %0d saturated %0b",
                  $time, got_length, got_saturated);
         failures++;
         return;
      end
      want = expected_q.pop_front();
      if (got_length !== want.length) begin
         $display("%0t: match_length expected %0d actual %0d", $time, want.length, got_length);
         failures++;
      end
      if (got_saturated !== want.saturated) begin
         $display("%0t: length_saturated expected %0b actual %0b",
                  $time, want.saturated, got_saturated);
         failures++;
      end
   endfunction
endclass

module tb_numeric_literal_scanner;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CP_W-1:0]   req_code_point = '0;
   logic              req_scan_start = 1'b0;
   logic              req_text_end = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [OUT_W-1:0]  rsp_match_length;
   logic              rsp_length_saturated;

   literal_length_board board;

   // Sender state: words left in the current burst, and a switch that turns
   // the random gaps off while the block is being pushed into backpressure.
   int unsigned burst_left = 0;
   bit          no_gaps = 1'b0;
   int unsigned words_sent = 0;
   // Set by the stimulus to ask the result side for one long hold-off.
   bit          long_hold = 1'b0;

   // Characters of the scan being composed, sent in order by send_scan.
   logic [CP_W-1:0] scan_text[$];

   numeric_literal_scanner uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_code_point       (req_code_point),
      .req_scan_start       (req_scan_start),
      .req_text_end         (req_text_end),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_match_length     (rsp_match_length),
      .rsp_length_saturated (rsp_length_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("TEST FAILED");
      $finish;
   end

   // Offers one word and returns at the edge that accepts it. Words go out in
   // bursts of random length; between bursts valid drops for a random gap.
   // Signals are sampled right after the edge, so they still hold the values
   // the block saw at that edge.
   task automatic send_word(input logic [CP_W-1:0] cp, input logic start, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_code_point <= cp;
      req_scan_start <= start;
      req_text_end <= last;
      do @(posedge clock); while (req_stall);
      board.note_word(cp, start, last);
      words_sent++;
   endtask

   function automatic void push_from(input string alphabet, input int unsigned count);
      for (int i = 0; i < count; i++)
         scan_text.push_back({8'h00, alphabet[$urandom_range(0, alphabet.len() - 1)]});
   endfunction

   // Sends the composed characters as one scan: start on the first word, and
   // either text_end on the last one, an extra rejecting character, or nothing.
   task automatic send_scan(input scan_close_type how);
      int unsigned n;
      if (how == SCAN_CLOSE_REJECT) begin
         if ($urandom_range(0, 1) == 0) scan_text.push_back(CP_W'($urandom_range(16'h0080, 16'hFFFF)));
         else push_from(" ;)gzG,", 1);
      end
      n = scan_text.size();
      for (int i = 0; i < n; i++)
         send_word(scan_text[i], i == 0, how == SCAN_CLOSE_TEXT_END && i == n - 1);
      scan_text.delete();
   endtask

   task automatic send_text(input string s, input bit close);
      for (int i = 0; i < s.len(); i++) scan_text.push_back({8'h00, s[i]});
      send_scan(close ? SCAN_CLOSE_TEXT_END : SCAN_LEFT_OPEN);
   endtask

   // Pauses the sender until every expected result word has been taken.
   task automatic wait_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (board.outstanding() != 0);
   endtask

   // Builds one mostly well-formed literal with random content. Each shape
   // aims at a different part of the scanner: plain and fractional decimals,
   // leading dots, the three prefixed radixes, exponents that do or do not
   // get a digit, the odd starts, and plain noise.
   task automatic compose_literal();
      int unsigned shape;
      logic [CP_W-1:0] mark;
      shape = $urandom_range(0, 9);
      case (shape)
         0, 1: begin
            push_from("0123456789", 1);
            push_from("0123456789_", $urandom_range(0, 5));
         end
         2: begin
            push_from("0123456789", $urandom_range(1, 3));
            scan_text.push_back(CH_DOT);
            push_from("0123456789_", $urandom_range(0, 4));
         end
         3: begin
            scan_text.push_back(CH_DOT);
            push_from("0123456789_", $urandom_range(1, 4));
         end
         4, 5: begin
            scan_text.push_back(CH_0);
            push_from("xXbBoO", 1);
            mark = scan_text[$];
            // Now and then the digits come from the wrong set.
            if ($urandom_range(0, 3) == 0) push_from("0123456789abcdefABCDEF_", $urandom_range(1, 5));
            else if (mark == CH_LX || mark == CH_UX)
               push_from("0123456789abcdefABCDEF_", $urandom_range(1, 5));
            else if (mark == CH_LB || mark == CH_UB) push_from("01_", $urandom_range(1, 5));
            else push_from("01234567_", $urandom_range(1, 5));
         end
         6, 7: begin
            push_from("0123456789", $urandom_range(1, 2));
            if ($urandom_range(0, 2) == 0) begin
               scan_text.push_back(CH_DOT);
               push_from("0123456789", $urandom_range(0, 2));
            end
            push_from("eE", 1);
            if ($urandom_range(0, 1) == 0) push_from("+-_", 1);
            if ($urandom_range(0, 3) != 0) push_from("0123456789_", $urandom_range(0, 3));
         end
         8: begin
            push_from("e_nE", 1);
            push_from("0123456789_", $urandom_range(0, 3));
         end
         default: push_from("0123456789abcdefABCDEFxXbBoOeEnN_.+-z ", $urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 4) == 0) scan_text.push_back(CH_LN);
   endtask

   // Result side: checks every accepted result word and stalls on a randomly
   // chosen pattern, with runs of no stall at all. On request it holds off for
   // a long stretch so the block backs up.
   initial begin : result_sink
      int unsigned       pattern_left;
      int unsigned       hold_left;
      stall_pattern_type pattern;
      pattern_left = 0;
      hold_left = 0;
      pattern = STALL_NONE;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall)
            board.check_length(rsp_match_length, rsp_length_saturated);
         if (long_hold && hold_left == 0) begin
            hold_left = 60;
            long_hold = 1'b0;
         end
         if (pattern_left == 0) begin
            pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left = $urandom_range(20, 80);
         end
         pattern_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (pattern)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:     rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin : stimulus
      int unsigned     pick;
      scan_close_type  how;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words. A word while no scan is open is ignored.
      send_word(16'hFFFF, 1'b0, 1'b0);
      // A dot that is not followed by a digit gives length 0; the dot after
      // that decided scan is ignored.
      send_text(".x", 1'b0);
      send_word(CH_DOT, 1'b0, 1'b0);
      // Upper-case hex prefix with a trailing n, then binary cut off by a 2.
      send_text("0X1fn", 1'b0);
      send_text("0b12", 1'b0);
      // The exponent never gets a digit, so the length falls back to "1".
      send_text("1e+x", 1'b0);
      // Odd starts: "e5" and a lone n still match.
      send_text("e5", 1'b1);
      send_text("n", 1'b0);
      // A new start abandons the open scan without a result.
      send_text("1", 1'b0);
      send_text("3.", 1'b1);
      // Code point extremes as first characters.
      send_word(16'hFFFF, 1'b1, 1'b0);
      send_word(16'h0000, 1'b1, 1'b1);
      // Underscore right after e, exponent digit, then n.
      send_text("5e_7n", 1'b0);

      // Back up the block: the result side holds off while one-character scans,
      // each giving a result, go in without gaps.
      wait_drained();
      long_hold = 1'b1;
      no_gaps = 1'b1;
      repeat (16) begin
         push_from("zn;", 1);
         send_scan(SCAN_LEFT_OPEN);
      end
      no_gaps = 1'b0;

      // One literal around the counter limit, so both a full-length and a
      // saturated length show up depending on the seed.
      push_from("0123456789_", $urandom_range(254, 258));
      send_scan($urandom_range(0, 1) ? SCAN_CLOSE_TEXT_END : SCAN_CLOSE_REJECT);

      while (words_sent < 550) begin
         compose_literal();
         pick = $urandom_range(0, 9);
         how = (pick < 4) ? SCAN_CLOSE_REJECT : (pick < 8) ? SCAN_CLOSE_TEXT_END : SCAN_LEFT_OPEN;
         send_scan(how);
         // Words after a scan carry no start; they are ignored once it is decided.
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
               send_word(CP_W'($urandom_range(0, 16'hFFFF)), 1'b0, 1'(($urandom_range(0, 1))));
         if ($urandom_range(0, 40) == 0) wait_drained();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
